// ===== sv/ismu_pkg.sv =====
// ----------------------------------------------------------------------------
// ismu_pkg
// Shared types and codes for the Ising Metropolis site update block.
// ----------------------------------------------------------------------------
package ismu_pkg;

   localparam int THRESH_W   = 17;
   localparam int RAND_W     = 16;
   localparam int COORD_IN_W = 7;
   localparam int ENERGY_W   = 6;
   localparam int CSR_IDX_W  = 1;

   // item function codes
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_PROPOSE = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RISE8  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE16 = 1'b1;

   typedef logic [THRESH_W-1:0] thresh_type;
   typedef logic [RAND_W-1:0]   rand_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ2,
      ST_EVAL
   } state_type;

endpackage

// ===== sv/ismu_ram.sv =====
// ----------------------------------------------------------------------------
// ismu_ram
// Generic synchronous RAM: one bit-masked write port, two registered read ports.
// ----------------------------------------------------------------------------
module ismu_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [WIDTH-1:0]         wr_mask,
   input  logic                     rd_en_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic                     rd_en_b,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (wr_mask[i]) begin
               mem_ff[wr_addr][i] <= wr_data[i];
            end
         end
      end
      if (rd_en_a) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== sv/ising_metropolis_site_update.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis single-site update on a SIDE x SIDE wrap-around spin lattice.
// ----------------------------------------------------------------------------
// The lattice is held one row per memory word. A load item writes one spin;
// a propose item reads the site row and the rows above and below, counts the
// neighbours that match the site spin, and flips the spin when the energy
// change is not positive or the random fraction lies below the threshold
// for a rise of 8 or 16. Every item gives one result item.
// Thresholds must be written on the csr_ port only while the block is idle;
// the block itself does not enforce it. A load passes the final step to the
// output register, a proposal the row read step first. One load is taken per
// cycle while results drain; no item is taken in a row read. The three row
// reads share the memory's two read ports, and a write back at the same edge
// as the next read is forwarded. A result waits in an output register; the
// next item is still taken, and the block holds at its last step only while
// that register stays full. Reset clears the control state and both
// thresholds; lattice contents are undefined until loaded.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update #(
   parameter int SIDE = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [ismu_pkg::COORD_IN_W-1:0]   req_row,
   input  logic [ismu_pkg::COORD_IN_W-1:0]   req_col,
   input  logic                              req_load_spin,
   input  logic [ismu_pkg::RAND_W-1:0]       req_uniform_random,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic                              rsp_spin_after,
   output logic signed [ismu_pkg::ENERGY_W-1:0] rsp_energy_change,
   input  logic                              csr_wr_en,
   input  logic [ismu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ismu_pkg::THRESH_W-1:0]     csr_wr_data
);

   import ismu_pkg::*;

   localparam int CW       = $clog2(SIDE);
   localparam int COORD_IN = 1 << COORD_IN_W;

   function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v);
      wrap_inc = (v == CW'(SIDE - 1)) ? '0 : v + CW'(1);
   endfunction

   function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] v);
      wrap_dec = (v == '0) ? CW'(SIDE - 1) : v - CW'(1);
   endfunction

   // coordinate reduction table
   logic [CW-1:0] coord_mod [COORD_IN];
   for (genvar g = 0; g < COORD_IN; g++) begin : g_mod
      assign coord_mod[g] = CW'(g % SIDE);
   end

   state_type        state_ff, state_in;
   logic             func_ff;
   logic [CW-1:0]    row_ff, col_ff;
   logic             spin_ld_ff;
   rand_type         rnd_ff;
   logic             s_ff, up_ff, left_ff, right_ff;
   thresh_type       th8_ff, th16_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_acc_ff, rsp_spin_ff;
   logic signed [ENERGY_W-1:0] rsp_de_ff;
   logic             fwd_valid_ff;
   logic [CW-1:0]    fwd_row_ff, fwd_col_ff;
   logic             fwd_bit_ff;

   logic             req_accept, eval_done;
   logic [CW-1:0]    req_row_m, req_col_m;
   logic [CW-1:0]    row_up, row_dn, col_l, col_r;
   logic             ram_wr_en, ram_rd_en_a, ram_rd_en_b, wr_bit;
   logic [CW-1:0]    ram_rd_addr_b;
   logic [SIDE-1:0]  ram_wr_data, ram_wr_mask, rd_data_a, rd_data_b;
   logic             hit_c, hit_up, s_cap, up_cap, left_cap, right_cap;
   logic             down_bit, flip_ok;
   logic [2:0]       match_cnt;
   logic [ENERGY_W-1:0] de_raw;

   assign req_row_m  = coord_mod[req_row];
   assign req_col_m  = coord_mod[req_col];
   assign req_accept = req_valid && req_ready;
   assign row_up     = wrap_dec(row_ff);
   assign row_dn     = wrap_inc(row_ff);
   assign col_l      = wrap_dec(col_ff);
   assign col_r      = wrap_inc(col_ff);

   ismu_ram #(
      .WIDTH (SIDE),
      .DEPTH (SIDE)
   ) u_lattice (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (row_ff),
      .wr_data   (ram_wr_data),
      .wr_mask   (ram_wr_mask),
      .rd_en_a   (ram_rd_en_a),
      .rd_addr_a (req_row_m),
      .rd_data_a (rd_data_a),
      .rd_en_b   (ram_rd_en_b),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // forward a write that lands on the same edge as the first row reads
   assign hit_c     = fwd_valid_ff && (fwd_row_ff == row_ff);
   assign hit_up    = fwd_valid_ff && (fwd_row_ff == row_up) && (fwd_col_ff == col_ff);
   assign s_cap     = (hit_c && fwd_col_ff == col_ff) ? fwd_bit_ff : rd_data_a[col_ff];
   assign left_cap  = (hit_c && fwd_col_ff == col_l)  ? fwd_bit_ff : rd_data_a[col_l];
   assign right_cap = (hit_c && fwd_col_ff == col_r)  ? fwd_bit_ff : rd_data_a[col_r];
   assign up_cap    = hit_up ? fwd_bit_ff : rd_data_b[col_ff];

   // energy change and acceptance
   assign down_bit  = rd_data_b[col_ff];
   assign match_cnt = 3'($countones({~(up_ff ^ s_ff), ~(down_bit ^ s_ff),
                                     ~(left_ff ^ s_ff), ~(right_ff ^ s_ff)}));
   assign de_raw    = ENERGY_W'({match_cnt, 3'b000}) - ENERGY_W'(16);

   always_comb begin
      priority if (match_cnt <= 3'd2) begin
         flip_ok = 1'b1;
      end else if (match_cnt == 3'd3) begin
         flip_ok = {1'b0, rnd_ff} < th8_ff;
      end else begin
         flip_ok = {1'b0, rnd_ff} < th16_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) begin
            state_in = (req_func == FUNC_PROPOSE) ? ST_READ2 : ST_EVAL;
         end
         ST_READ2: state_in = ST_EVAL;
         ST_EVAL:  if (req_accept) begin
            state_in = (req_func == FUNC_PROPOSE) ? ST_READ2 : ST_EVAL;
         end else if (eval_done) begin
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      eval_done     = 1'b0;
      req_ready     = 1'b0;
      ram_rd_en_b   = 1'b0;
      ram_rd_addr_b = wrap_dec(req_row_m);
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_READ2: begin
            ram_rd_en_b   = 1'b1;
            ram_rd_addr_b = row_dn;
         end
         ST_EVAL:  begin
            eval_done = !rsp_valid_ff || rsp_ready;
            req_ready = eval_done;
         end
         default:  req_ready = 1'b0;
      endcase
      if (req_valid && req_ready) begin
         ram_rd_en_b = 1'b1;
      end
   end

   assign ram_rd_en_a  = req_accept;
   assign wr_bit       = (func_ff == FUNC_LOAD) ? spin_ld_ff : ~s_ff;
   assign ram_wr_en    = eval_done && ((func_ff == FUNC_LOAD) || flip_ok);
   assign ram_wr_data  = {SIDE{wr_bit}};
   assign ram_wr_mask  = SIDE'(1) << col_ff;
   assign rsp_valid_in = eval_done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         th8_ff       <= '0;
         th16_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_valid_ff <= ram_wr_en;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RISE8:  th8_ff  <= csr_wr_data;
               CSR_RISE16: th16_ff <= csr_wr_data;
               default:    th8_ff  <= th8_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff    <= req_func;
         row_ff     <= req_row_m;
         col_ff     <= req_col_m;
         spin_ld_ff <= req_load_spin;
         rnd_ff     <= req_uniform_random;
      end
      if (state_ff == ST_READ2) begin
         s_ff     <= s_cap;
         up_ff    <= up_cap;
         left_ff  <= left_cap;
         right_ff <= right_cap;
      end
      if (ram_wr_en) begin
         fwd_row_ff <= row_ff;
         fwd_col_ff <= col_ff;
         fwd_bit_ff <= wr_bit;
      end
      if (eval_done) begin
         if (func_ff == FUNC_LOAD) begin
            rsp_acc_ff  <= 1'b1;
            rsp_spin_ff <= spin_ld_ff;
            rsp_de_ff   <= '0;
         end else begin
            rsp_acc_ff  <= flip_ok;
            rsp_spin_ff <= flip_ok ? ~s_ff : s_ff;
            rsp_de_ff   <= signed'(de_raw);
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_spin_after    = rsp_spin_ff;
   assign rsp_energy_change = rsp_de_ff;

   a_write_in_eval : assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == ST_EVAL)
      else $error("lattice write outside final step");

   a_no_take_in_read2 : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ2 |-> !req_ready)
      else $error("item taken during row read");

   a_hold_when_full : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_EVAL)
      else $error("result dropped while output register full");

   a_load_result : assert property (@(posedge clock) disable iff (reset)
      (eval_done && func_ff == FUNC_LOAD) |=>
         (rsp_valid && rsp_accepted && rsp_energy_change == '0))
      else $error("load result malformed");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Ising Metropolis site update block.
// ----------------------------------------------------------------------------
// Loads wrap-around corner neighborhoods and then runs random load and propose
// traffic. Proposals only ever target sites whose centre and four neighbors
// have been loaded. A scoreboard keeps its own lattice and thresholds, and
// predicts the energy change, the flip decision and the new spin for every
// item. Both channels stall at random. Thresholds are rewritten between
// phases once all results are in, including zero, one, full scale and values
// above full scale.
// ----------------------------------------------------------------------------

localparam int LATTICE_SIDE = 128;

typedef struct packed {
   logic                                accepted;
   logic                                spin_after;
   logic signed [ismu_pkg::ENERGY_W-1:0] energy_change;
} site_update_type;

function automatic int lattice_addr(int r, int c);
   return ((r + LATTICE_SIDE) % LATTICE_SIDE) * LATTICE_SIDE
          + ((c + LATTICE_SIDE) % LATTICE_SIDE);
endfunction

class lattice_scoreboard;
   bit                   spins [LATTICE_SIDE*LATTICE_SIDE];
   ismu_pkg::thresh_type rise8_limit;
   ismu_pkg::thresh_type rise16_limit;
   site_update_type      expected_updates [$];
   int                   failures;
   int                   loads;
   int                   proposals;
   int                   flips;
   int                   refusals;
   int                   change_count [5];

   function void set_threshold(logic [ismu_pkg::CSR_IDX_W-1:0] idx,
                               ismu_pkg::thresh_type value);
      if (idx == ismu_pkg::CSR_RISE8) begin
         rise8_limit = value;
      end else begin
         rise16_limit = value;
      end
   endfunction

   function int spin_at(int r, int c);
      return spins[lattice_addr(r, c)] ? 1 : -1;
   endfunction

   function void predict_update(logic func, int r, int c, logic load_spin,
                                ismu_pkg::rand_type rnd);
      site_update_type u;
      int              a;
      int              nsum;
      int              de;
      bit              take;
      a = lattice_addr(r, c);
      if (func == ismu_pkg::FUNC_LOAD) begin
         spins[a] = load_spin;
         loads++;
         u.accepted = 1'b1;
         u.spin_after = load_spin;
         u.energy_change = '0;
      end else begin
         nsum = spin_at(r + 1, c) + spin_at(r - 1, c) + spin_at(r, c + 1) + spin_at(r, c - 1);
         de = 4 * spin_at(r, c) * nsum;
         if (de <= 0) begin
            take = 1'b1;
         end else if (de == 8) begin
            take = int'(rnd) < int'(rise8_limit);
         end else begin
            take = int'(rnd) < int'(rise16_limit);
         end
         if (take) begin
            spins[a] = !spins[a];
            flips++;
         end else begin
            refusals++;
         end
         proposals++;
         change_count[(de + 16) / 8]++;
         u.accepted = take;
         u.spin_after = spins[a];
         u.energy_change = de[ismu_pkg::ENERGY_W-1:0];
      end
      expected_updates.push_back(u);
   endfunction

   function void check_update(logic acc, logic spin,
                              logic signed [ismu_pkg::ENERGY_W-1:0] de);
      site_update_type want;
      if (expected_updates.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("unexpected result: accepted=%0b spin_after=%0b energy_change=%0d",
                     acc, spin, de);
         end
         return;
      end
      want = expected_updates.pop_front();
      if (want.accepted !== acc || want.spin_after !== spin
          || want.energy_change !== de) begin
         failures++;
         if (failures <= 10) begin
            $display("mismatch: accepted exp %0b got %0b, spin_after exp %0b got %0b, %s%0d got %0d",
                     want.accepted, acc, want.spin_after, spin,
                     "energy_change exp ", want.energy_change, de);
         end
      end
   endfunction
endclass

module tb_top;

   localparam int QUIET_LIMIT = 4000;
   localparam int DIRECTED_ITEMS = 25;
   localparam int PHASE_ITEMS = 105;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic                                  req_func;
   logic [ismu_pkg::COORD_IN_W-1:0]       req_row;
   logic [ismu_pkg::COORD_IN_W-1:0]       req_col;
   logic                                  req_load_spin;
   ismu_pkg::rand_type                    req_uniform_random;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic                                  rsp_accepted;
   logic                                  rsp_spin_after;
   logic signed [ismu_pkg::ENERGY_W-1:0]  rsp_energy_change;
   logic                                  csr_wr_en;
   logic [ismu_pkg::CSR_IDX_W-1:0]        csr_index;
   ismu_pkg::thresh_type                  csr_wr_data;

   lattice_scoreboard sb;
   bit                written [LATTICE_SIDE*LATTICE_SIDE];
   bit                site_ready [LATTICE_SIDE*LATTICE_SIDE];
   int                ready_sites [$];
   int                items_sent;
   int                quiet_cycles;
   bit                steady;

   ising_metropolis_site_update #(
      .SIDE (LATTICE_SIDE)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_load_spin      (req_load_spin),
      .req_uniform_random (req_uniform_random),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_spin_after     (rsp_spin_after),
      .rsp_energy_change  (rsp_energy_change),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.predict_update(req_func, req_row, req_col, req_load_spin, req_uniform_random);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_update(rsp_accepted, rsp_spin_after, rsp_energy_change);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic bit neighborhood_loaded(int r, int c);
      return written[lattice_addr(r, c)] && written[lattice_addr(r + 1, c)]
             && written[lattice_addr(r - 1, c)] && written[lattice_addr(r, c + 1)]
             && written[lattice_addr(r, c - 1)];
   endfunction

   function automatic void enlist_if_ready(int r, int c);
      int a;
      a = lattice_addr(r, c);
      if (!site_ready[a] && neighborhood_loaded(r, c)) begin
         site_ready[a] = 1'b1;
         ready_sites.push_back(a);
      end
   endfunction

   function automatic int pick_coord();
      if ($urandom_range(3) == 0) begin
         return $urandom_range(1) ? LATTICE_SIDE - 1 : 0;
      end
      return $urandom_range(LATTICE_SIDE - 1);
   endfunction

   function automatic ismu_pkg::rand_type near_limit(ismu_pkg::thresh_type lim);
      int v;
      v = int'(lim) + int'($urandom_range(3)) - 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   task automatic send_item(input logic func, input int r, input int c, input logic spin,
                            input ismu_pkg::rand_type rnd);
      int a;
      int gap;
      a = lattice_addr(r, c);
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < 30) gap++;
      end
      @(negedge clock);
      while (gap > 0) begin
         req_valid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_row <= a / LATTICE_SIDE;
      req_col <= a % LATTICE_SIDE;
      req_load_spin <= spin;
      req_uniform_random <= rnd;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
   endtask

   task automatic load_site(input int r, input int c, input logic spin);
      ismu_pkg::rand_type junk;
      junk = $urandom;
      send_item(ismu_pkg::FUNC_LOAD, r, c, spin, junk);
      written[lattice_addr(r, c)] = 1'b1;
      enlist_if_ready(r, c);
      enlist_if_ready(r + 1, c);
      enlist_if_ready(r - 1, c);
      enlist_if_ready(r, c + 1);
      enlist_if_ready(r, c - 1);
   endtask

   task automatic propose_site(input int r, input int c, input ismu_pkg::rand_type rnd);
      send_item(ismu_pkg::FUNC_PROPOSE, r, c, $urandom_range(1), rnd);
   endtask

   // wait until every result is back and the block has gone quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_updates.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [ismu_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value[ismu_pkg::THRESH_W-1:0];
      sb.set_threshold(idx, value[ismu_pkg::THRESH_W-1:0]);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int                 r;
      int                 c;
      int                 a;
      int                 k;
      int                 mode;
      int                 pick;
      int                 phase;
      int                 th8;
      int                 th16;
      logic               center;
      logic               nb;
      ismu_pkg::rand_type rnd;

      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = ismu_pkg::FUNC_LOAD;
      req_row = '0;
      req_col = '0;
      req_load_spin = 1'b0;
      req_uniform_random = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = ismu_pkg::CSR_RISE8;
      csr_wr_data = '0;
      items_sent = 0;
      quiet_cycles = 0;
      steady = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner neighborhoods exercising wrap-around on both axes
      write_threshold(ismu_pkg::CSR_RISE8, 0);
      write_threshold(ismu_pkg::CSR_RISE16, 0);
      load_site(0, 0, 1'b1);
      load_site(1, 0, 1'b1);
      load_site(LATTICE_SIDE - 1, 0, 1'b1);
      load_site(0, 1, 1'b1);
      load_site(0, LATTICE_SIDE - 1, 1'b1);
      propose_site(0, 0, 16'h0000);
      load_site(LATTICE_SIDE - 1, LATTICE_SIDE - 1, 1'b0);
      load_site(LATTICE_SIDE - 2, LATTICE_SIDE - 1, 1'b1);
      load_site(LATTICE_SIDE - 1, LATTICE_SIDE - 2, 1'b1);
      propose_site(LATTICE_SIDE - 1, LATTICE_SIDE - 1, 16'hFFFF);
      propose_site(LATTICE_SIDE - 1, LATTICE_SIDE - 1, 16'h0000);
      load_site(0, 1, 1'b0);
      propose_site(0, 0, 16'h0000);
      load_site(1, 0, 1'b0);
      propose_site(0, 0, 16'h5A5A);
      propose_site(0, 0, 16'hA5A5);
      load_site(LATTICE_SIDE - 1, 0, 1'b0);
      propose_site(0, 0, 16'hFFFF);

      // full-scale and oversized bounds
      settle();
      write_threshold(ismu_pkg::CSR_RISE8, 65536);
      write_threshold(ismu_pkg::CSR_RISE16, 131071);
      propose_site(0, 0, 16'hFFFF);
      propose_site(LATTICE_SIDE - 1, LATTICE_SIDE - 1, 16'hFFFF);

      // compare boundary: random equal to the bound is refused
      settle();
      write_threshold(ismu_pkg::CSR_RISE8, 1);
      write_threshold(ismu_pkg::CSR_RISE16, 65535);
      propose_site(LATTICE_SIDE - 1, LATTICE_SIDE - 1, 16'hFFFF);
      propose_site(LATTICE_SIDE - 1, LATTICE_SIDE - 1, 16'hFFFF);
      propose_site(LATTICE_SIDE - 1, LATTICE_SIDE - 1, 16'hFFFE);
      propose_site(0, 0, 16'h0001);
      propose_site(0, 0, 16'h0000);

      for (phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            0: begin
               th8 = $urandom_range(65536);
               th16 = int'((longint'(th8) * th8) >>> 16);
            end
            1: begin
               th8 = 0;
               th16 = 0;
            end
            2: begin
               th8 = 65536;
               th16 = 131071;
            end
            3: begin
               th8 = 131071;
               th16 = 65536;
            end
            default: begin
               th8 = $urandom_range(65535, 1);
               th16 = $urandom_range(65535);
            end
         endcase
         write_threshold(ismu_pkg::CSR_RISE8, th8);
         write_threshold(ismu_pkg::CSR_RISE16, th16);
         steady = (phase == 2);
         while (items_sent < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 15 || ready_sites.size() == 0) begin
               // fresh neighborhood, sometimes aligned or anti-aligned
               r = pick_coord();
               c = pick_coord();
               center = $urandom_range(1);
               mode = $urandom_range(2);
               load_site(r, c, center);
               for (k = 0; k < 4; k++) begin
                  case (mode)
                     0: nb = $urandom_range(1);
                     1: nb = center;
                     default: nb = !center;
                  endcase
                  case (k)
                     0: load_site(r + 1, c, nb);
                     1: load_site(r - 1, c, nb);
                     2: load_site(r, c + 1, nb);
                     default: load_site(r, c - 1, nb);
                  endcase
               end
            end else if (pick < 30) begin
               if ($urandom_range(2) == 0) begin
                  a = ready_sites[$urandom_range(ready_sites.size() - 1)];
                  r = a / LATTICE_SIDE;
                  c = a % LATTICE_SIDE;
               end else begin
                  r = $urandom_range(LATTICE_SIDE - 1);
                  c = $urandom_range(LATTICE_SIDE - 1);
               end
               load_site(r, c, $urandom_range(1));
            end else begin
               if ($urandom_range(1) == 1) begin
                  a = ready_sites[$];
               end else begin
                  a = ready_sites[$urandom_range(ready_sites.size() - 1)];
               end
               case ($urandom_range(3))
                  0, 1: rnd = $urandom;
                  2: rnd = near_limit(sb.rise8_limit);
                  default: rnd = near_limit(sb.rise16_limit);
               endcase
               propose_site(a / LATTICE_SIDE, a % LATTICE_SIDE, rnd);
            end
         end
      end

      steady = 1'b0;
      settle();
      repeat (10) @(posedge clock);
      if (sb.expected_updates.size() != 0) begin
         sb.failures++;
         $display("%0d expected results never arrived", sb.expected_updates.size());
      end
      $display("ran %0d loads and %0d proposals over eight bound settings, %0d flips taken, %0d refused",
               sb.loads, sb.proposals, sb.flips, sb.refusals);
      $display("energy changes seen: -16:%0d -8:%0d 0:%0d +8:%0d +16:%0d",
               sb.change_count[0], sb.change_count[1], sb.change_count[2],
               sb.change_count[3], sb.change_count[4]);
      if (sb.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
